// File: design/cpdc_pkg.sv
package cpdc_pkg;

    localparam int COORD_WIDTH     = 16;
    localparam int COEF_WIDTH_DFLT = 48;
    localparam int LIMB_W          = 24;   // operand slice of the multiplier array
    localparam int DIST_W          = 32;
    localparam int CFG_IDX_W       = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_COEF_XX    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_XY    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_X     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_YY    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_Y     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_CONST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y   = 3'd7;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] point_x;
        logic signed [COORD_WIDTH-1:0] point_y;
    } t_item;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              inside_res;
        logic              saturated;
    } t_res;

    // half gradient width (scale 2^-28)
    function automatic int u_width(input int kw);
        return COORD_WIDTH + kw + 2;
    endfunction

    // conic value width (scale 2^-32)
    function automatic int q_width(input int kw);
        return 2 * COORD_WIDTH + kw + 4;
    endfunction

    // cycles through one limb-sliced multiplier
    function automatic int mul_lat(input int aw, input int bw);
        return ((aw + LIMB_W - 1) / LIMB_W) * ((bw + LIMB_W - 1) / LIMB_W);
    endfunction

    // start to strobe
    function automatic int pipe_lat(input int kw);
        return 5 + DIST_W + mul_lat(COORD_WIDTH, kw)
             + mul_lat(COORD_WIDTH, u_width(kw)) + mul_lat(q_width(kw), q_width(kw));
    endfunction

endpackage

// File: design/cpdc_mul.sv
module cpdc_mul #(
    parameter int AW = 16,
    parameter int BW = 48
) (
    input  logic                 i_clk,
    input  logic signed [AW-1:0] i_a,
    input  logic signed [BW-1:0] i_b,
    output logic [AW+BW-1:0]     o_p
);
    import cpdc_pkg::*;

    localparam int NA  = (AW + LIMB_W - 1) / LIMB_W;
    localparam int NB  = (BW + LIMB_W - 1) / LIMB_W;
    localparam int NP  = NA * NB;
    localparam int PW  = AW + BW;
    localparam int PPW = 2 * LIMB_W + 2;
    localparam int AXW = NA * LIMB_W;
    localparam int BXW = NB * LIMB_W;
    localparam int EXW = PW + PPW;

    logic [AXW-1:0]          w_a_ext;
    logic [BXW-1:0]          w_b_ext;
    logic signed [LIMB_W:0]  w_al [NA];
    logic signed [LIMB_W:0]  w_bl [NB];
    logic signed [PPW-1:0]   w_pp [NP];

    logic signed [PPW-1:0]   r_pp  [NP][NP];
    logic [PW-1:0]           r_acc [NP];

    // place a slice product at its weight, modulo 2^PW (the full product fits PW)
    function automatic logic [PW-1:0] place(input logic signed [PPW-1:0] pp, input int sh);
        logic signed [EXW-1:0] ext;
        ext = EXW'(pp);
        return PW'(ext <<< sh);
    endfunction

    assign w_a_ext = AXW'(i_a);
    assign w_b_ext = BXW'(i_b);

    // low slices unsigned, top slice carries the sign
    for (genvar i = 0; i < NA; i++) begin : g_al
        if (i == NA - 1) begin : g_top
            assign w_al[i] = {w_a_ext[i*LIMB_W+LIMB_W-1], w_a_ext[i*LIMB_W +: LIMB_W]};
        end else begin : g_low
            assign w_al[i] = {1'b0, w_a_ext[i*LIMB_W +: LIMB_W]};
        end
    end

    for (genvar j = 0; j < NB; j++) begin : g_bl
        if (j == NB - 1) begin : g_top
            assign w_bl[j] = {w_b_ext[j*LIMB_W+LIMB_W-1], w_b_ext[j*LIMB_W +: LIMB_W]};
        end else begin : g_low
            assign w_bl[j] = {1'b0, w_b_ext[j*LIMB_W +: LIMB_W]};
        end
    end

    for (genvar i = 0; i < NA; i++) begin : g_ppi
        for (genvar j = 0; j < NB; j++) begin : g_ppj
            assign w_pp[i*NB+j] = w_al[i] * w_bl[j];
        end
    end

    // stage 0 registers all slice products, then one slice is added per stage
    always_ff @(posedge i_clk) begin
        r_acc[0] <= place(w_pp[0], 0);
        for (int k = 1; k < NP; k++) begin
            r_pp[0][k] <= w_pp[k];
        end
        for (int s = 1; s < NP; s++) begin
            r_acc[s] <= r_acc[s-1] + place(r_pp[s-1][s], ((s / NB) + (s % NB)) * LIMB_W);
            for (int k = s + 1; k < NP; k++) begin
                r_pp[s][k] <= r_pp[s-1][k];
            end
        end
    end

    assign o_p = r_acc[NP-1];

endmodule

// File: design/conic_point_distance_classifier_core.sv
// Conic point distance classifier.
// Input: one point word per cycle. A word is taken at a clock edge with i_start
// high and o_busy low; o_busy is always low, so a point may be offered every cycle.
// Output: one result word per point, in order, shown on o_res for one cycle with
// o_strobe high. The receiver cannot hold results off and need not.
// Path: an accepted point passes the input register, the coefficient multipliers,
// the stage B register, the gradient multipliers, the stage C register, the
// conic-square multiplier (all in 24-bit slices), the divider and the output register.
// Throughput: one point per cycle. The 32-step restoring divider is fully
// unrolled, one quotient bit per stage, and sets the depth.
// Config: write port i_cfg_we / i_cfg_idx / i_cfg_wdata, taken on the edge,
// effective for points accepted after the write. Write only while no point is
// in flight.
// Reset: clears every valid bit (points in flight are dropped) and loads the
// unit circle: xx = yy = 1.0, const = -1.0, other terms and the centre zero.
module conic_point_distance_classifier_core #(
    parameter int COEF_WIDTH = cpdc_pkg::COEF_WIDTH_DFLT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  cpdc_pkg::t_item                i_item,
    output logic                           o_busy,
    output logic                           o_strobe,
    output cpdc_pkg::t_res                 o_res,
    input  logic                           i_cfg_we,
    input  logic [cpdc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [COEF_WIDTH-1:0]          i_cfg_wdata
);
    import cpdc_pkg::*;

    localparam int CW   = COORD_WIDTH;
    localparam int KW   = COEF_WIDTH;
    localparam int P1W  = CW + KW;
    localparam int UW   = u_width(KW);
    localparam int WW   = CW + KW + 6;
    localparam int QW   = q_width(KW);
    localparam int P2W  = CW + UW;
    localparam int SQW  = 2 * QW;
    localparam int UUW  = 2 * UW;
    localparam int DENW = UUW + 1;
    localparam int NUM_SHIFT = 8;
    localparam int NUMW = SQW + NUM_SHIFT;
    localparam int RW   = (NUMW > DENW + DIST_W) ? NUMW : DENW + DIST_W;
    localparam int DVW  = DIST_W + 1;
    localparam int N_P1 = 6;
    localparam int L1   = mul_lat(CW, KW);
    localparam int L2   = mul_lat(CW, UW);
    localparam int L3   = mul_lat(UW, UW);
    localparam int L4   = mul_lat(QW, QW);
    localparam int DD   = L2 + 1 + L4 - L3;

    localparam logic signed [KW-1:0] ONE_RST     = KW'(64'sd16777216);
    localparam logic signed [KW-1:0] NEG_ONE_RST = KW'(-64'sd16777216);

    // configuration
    logic signed [KW-1:0] r_cxx, r_cxy, r_cx1, r_cyy, r_cy1, r_cc;
    logic signed [CW-1:0] r_ctr_x, r_ctr_y;

    // stage A: input word
    logic                 r_a_vld;
    t_item                r_a;

    // pass 1: point (0) and centre (1)
    logic signed [CW-1:0]  w_sx [2];
    logic signed [CW-1:0]  w_sy [2];
    logic signed [KW-1:0]  w_k1 [N_P1];
    logic [P1W-1:0]        w_m1 [2][N_P1];
    logic signed [CW-1:0]  r_dx [L1];
    logic signed [CW-1:0]  r_dy [L1];
    logic [L1-1:0]         r_v1;

    // stage B: half gradients and linear part
    logic signed [UW-1:0]  n_u [2];
    logic signed [UW-1:0]  n_v [2];
    logic signed [WW-1:0]  n_w [2];
    logic signed [UW-1:0]  r_u [2];
    logic signed [UW-1:0]  r_v [2];
    logic signed [WW-1:0]  r_w [2];
    logic signed [CW-1:0]  r_bx, r_by;
    logic                  r_b_vld;

    // pass 2
    logic [P2W-1:0]        w_m2 [2][2];
    logic signed [WW-1:0]  r_wd [2][L2];
    logic [L2-1:0]         r_v2;
    logic [UUW-1:0]        w_uu, w_vv;
    logic [DENW-1:0]       w_den;
    logic [DENW-1:0]       r_dend [DD];

    // stage C: conic value (0) and polar form (1)
    logic signed [QW-1:0]  n_q [2];
    logic signed [QW-1:0]  r_q [2];
    logic                  r_c_vld;
    logic                  w_ins;
    logic [L4-1:0]         r_insd;
    logic [L4-1:0]         r_v4;
    logic [SQW-1:0]        w_qq;

    // divider
    logic [RW-1:0]         n_num;
    logic                  n_sat;
    logic [RW-1:0]         r_rem [DIST_W];
    logic [DENW-1:0]       r_dv  [DIST_W];
    logic [DIST_W-1:0]     r_quo [DVW];
    logic [RW:0]           w_trial [DIST_W];
    logic [DVW-1:0]        r_dsat, r_dins, r_dvld;

    assign o_busy = 1'b0;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cxx   <= ONE_RST;
            r_cxy   <= '0;
            r_cx1   <= '0;
            r_cyy   <= ONE_RST;
            r_cy1   <= '0;
            r_cc    <= NEG_ONE_RST;
            r_ctr_x <= '0;
            r_ctr_y <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_COEF_XX:    r_cxx   <= i_cfg_wdata;
                CFG_COEF_XY:    r_cxy   <= i_cfg_wdata;
                CFG_COEF_X:     r_cx1   <= i_cfg_wdata;
                CFG_COEF_YY:    r_cyy   <= i_cfg_wdata;
                CFG_COEF_Y:     r_cy1   <= i_cfg_wdata;
                CFG_COEF_CONST: r_cc    <= i_cfg_wdata;
                CFG_CENTER_X:   r_ctr_x <= i_cfg_wdata[CW-1:0];
                CFG_CENTER_Y:   r_ctr_y <= i_cfg_wdata[CW-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- valid chain ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld  <= 1'b0;
            r_v1     <= '0;
            r_b_vld  <= 1'b0;
            r_v2     <= '0;
            r_c_vld  <= 1'b0;
            r_v4     <= '0;
            r_dvld   <= '0;
            o_strobe <= 1'b0;
        end else begin
            r_a_vld  <= i_start && !o_busy;
            r_v1     <= L1'({r_v1, r_a_vld});
            r_b_vld  <= r_v1[L1-1];
            r_v2     <= L2'({r_v2, r_b_vld});
            r_c_vld  <= r_v2[L2-1];
            r_v4     <= L4'({r_v4, r_c_vld});
            r_dvld   <= DVW'({r_dvld, r_v4[L4-1]});
            o_strobe <= r_dvld[DIST_W];
        end
    end

    // ---------------- stage A ----------------
    always_ff @(posedge i_clk) begin
        r_a <= i_item;
    end

    // ---------------- pass 1 ----------------
    assign w_sx[0] = r_a.point_x;
    assign w_sy[0] = r_a.point_y;
    assign w_sx[1] = r_ctr_x;
    assign w_sy[1] = r_ctr_y;

    // even slots take x, odd slots take y
    assign w_k1[0] = r_cxx;
    assign w_k1[1] = r_cxy;
    assign w_k1[2] = r_cxy;
    assign w_k1[3] = r_cyy;
    assign w_k1[4] = r_cx1;
    assign w_k1[5] = r_cy1;

    for (genvar g = 0; g < 2; g++) begin : g_p1
        for (genvar k = 0; k < N_P1; k++) begin : g_m
            cpdc_mul #(.AW(CW), .BW(KW)) u_mul (
                .i_clk (i_clk),
                .i_a   ((k % 2 == 0) ? w_sx[g] : w_sy[g]),
                .i_b   (w_k1[k]),
                .o_p   (w_m1[g][k])
            );
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx[0] <= r_a.point_x;
        r_dy[0] <= r_a.point_y;
        for (int i = 1; i < L1; i++) begin
            r_dx[i] <= r_dx[i-1];
            r_dy[i] <= r_dy[i-1];
        end
    end

    // ---------------- stage B ----------------
    always_comb begin
        for (int g = 0; g < 2; g++) begin
            n_u[g] = UW'($signed(w_m1[g][0])) + UW'($signed(w_m1[g][1])) + (UW'(r_cx1) <<< 4);
            n_v[g] = UW'($signed(w_m1[g][2])) + UW'($signed(w_m1[g][3])) + (UW'(r_cy1) <<< 4);
            n_w[g] = ((WW'($signed(w_m1[g][4])) + WW'($signed(w_m1[g][5]))) <<< 4)
                   + (WW'(r_cc) <<< 8);
        end
    end

    always_ff @(posedge i_clk) begin
        r_u  <= n_u;
        r_v  <= n_v;
        r_w  <= n_w;
        r_bx <= r_dx[L1-1];
        r_by <= r_dy[L1-1];
    end

    // ---------------- pass 2 ----------------
    for (genvar g = 0; g < 2; g++) begin : g_p2
        cpdc_mul #(.AW(CW), .BW(UW)) u_mul_x (
            .i_clk (i_clk),
            .i_a   (r_bx),
            .i_b   (r_u[g]),
            .o_p   (w_m2[g][0])
        );
        cpdc_mul #(.AW(CW), .BW(UW)) u_mul_y (
            .i_clk (i_clk),
            .i_a   (r_by),
            .i_b   (r_v[g]),
            .o_p   (w_m2[g][1])
        );
    end

    cpdc_mul #(.AW(UW), .BW(UW)) u_mul_uu (
        .i_clk (i_clk),
        .i_a   (r_u[0]),
        .i_b   (r_u[0]),
        .o_p   (w_uu)
    );

    cpdc_mul #(.AW(UW), .BW(UW)) u_mul_vv (
        .i_clk (i_clk),
        .i_a   (r_v[0]),
        .i_b   (r_v[0]),
        .o_p   (w_vv)
    );

    // squares are non-negative, so zero extension is exact
    assign w_den = DENW'(w_uu) + DENW'(w_vv);

    always_ff @(posedge i_clk) begin
        for (int g = 0; g < 2; g++) begin
            r_wd[g][0] <= r_w[g];
            for (int i = 1; i < L2; i++) begin
                r_wd[g][i] <= r_wd[g][i-1];
            end
        end
        // line up the denominator with the squared conic value
        r_dend[0] <= w_den;
        for (int i = 1; i < DD; i++) begin
            r_dend[i] <= r_dend[i-1];
        end
    end

    // ---------------- stage C ----------------
    always_comb begin
        for (int g = 0; g < 2; g++) begin
            n_q[g] = QW'($signed(w_m2[g][0])) + QW'($signed(w_m2[g][1])) + QW'(r_wd[g][L2-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign w_ins = (r_q[0] != '0) && (r_q[1] != '0) && (r_q[0][QW-1] == r_q[1][QW-1]);

    cpdc_mul #(.AW(QW), .BW(QW)) u_mul_qq (
        .i_clk (i_clk),
        .i_a   (r_q[0]),
        .i_b   (r_q[0]),
        .o_p   (w_qq)
    );

    always_ff @(posedge i_clk) begin
        r_insd <= L4'({r_insd, w_ins});
    end

    // ---------------- divider ----------------
    assign n_num = RW'({w_qq, {NUM_SHIFT{1'b0}}});
    assign n_sat = (r_dend[DD-1] == '0) || (n_num >= (RW'(r_dend[DD-1]) << DIST_W));

    always_comb begin
        for (int i = 0; i < DIST_W; i++) begin
            w_trial[i] = {1'b0, r_rem[i]} - {1'b0, (RW'(r_dv[i]) << (DIST_W - 1 - i))};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0] <= n_num;
        r_dv[0]  <= r_dend[DD-1];
        r_quo[0] <= '0;
        r_dsat   <= DVW'({r_dsat, n_sat});
        r_dins   <= DVW'({r_dins, r_insd[L4-1]});
        for (int i = 0; i < DIST_W; i++) begin
            // one quotient bit per stage, MSB first
            r_quo[i+1] <= {r_quo[i][DIST_W-2:0], !w_trial[i][RW]};
            if (i < DIST_W - 1) begin
                r_rem[i+1] <= w_trial[i][RW] ? r_rem[i] : w_trial[i][RW-1:0];
                r_dv[i+1]  <= r_dv[i];
            end
        end
    end

    // ---------------- output ----------------
    always_ff @(posedge i_clk) begin
        o_res.distance   <= r_dsat[DIST_W] ? '1 : r_quo[DIST_W];
        o_res.inside_res <= r_dins[DIST_W];
        o_res.saturated  <= r_dsat[DIST_W];
    end

endmodule

// File: design/cpdc_checker.sv
module cpdc_checker #(
    parameter int COEF_WIDTH = cpdc_pkg::COEF_WIDTH_DFLT
) (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_start,
    input logic           o_busy,
    input logic           o_strobe,
    input cpdc_pkg::t_res o_res
);
    import cpdc_pkg::*;

    localparam int LAT = pipe_lat(COEF_WIDTH);

    logic w_acc;

    assign w_acc = i_start && !o_busy;

    // every accepted word comes out as a result strobe at the pipeline latency
    a_lat_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |-> ##LAT o_strobe)
        else $error("accepted word not delivered after pipeline latency");

    // and nothing comes out that was not accepted
    a_lat_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(w_acc && i_rst_n, LAT))
        else $error("result word without matching accepted word");

    a_sat_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_res.saturated) |-> (o_res.distance == '1))
        else $error("saturated result with distance below full scale");

    a_rst_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe)
        else $error("result strobe right after reset");

endmodule

bind conic_point_distance_classifier_core cpdc_checker #(
    .COEF_WIDTH(COEF_WIDTH)
) u_cpdc_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (i_start),
    .o_busy   (o_busy),
    .o_strobe (o_strobe),
    .o_res    (o_res)
);
